/* rtl/core/tsavs_pkg.sv */
// ----------------------------------------------------------------------------
// tsavs_pkg: shared types and constants of the two-stage averager
// Register indexes, reset values, saturation limits and the reciprocal
// constants used to divide by fixed numbers without a divider.
// ----------------------------------------------------------------------------
package tsavs_pkg;

	// Widest sample the datapath is built for
	localparam int SmpMaxW = 16;

	// Configuration register map
	typedef enum logic [1:0] {
		REG_THRESHOLD = 2'd0,
		REG_BLOCK_LEN = 2'd1,
		REG_AVG_LEN   = 2'd2
	} cfg_reg_t;

	localparam int CfgDataW = 12;

	localparam logic [11:0] THRESHOLD_RST = 12'd500;
	localparam logic [7:0]  BLOCK_LEN_RST = 8'd120;
	localparam logic [7:0]  AVG_LEN_RST   = 8'd40;

	// Accumulator limits
	localparam logic [20:0] SUM_MAX     = 21'h1F_FFFF;
	localparam logic [23:0] TOTAL_MAX   = 24'hFF_FFFF;
	localparam logic [16:0] SUM_Q_MAX   = 17'(SUM_MAX / 21'd20);
	localparam logic [4:0]  SUM_R_MAX   = 5'(SUM_MAX % 21'd20);

	// Voltage scaling
	localparam logic [7:0]  HI_GAIN     = 8'd236;
	localparam logic [6:0]  LO_GAIN     = 7'd120;
	localparam logic [13:0] LO_LIMIT    = 14'd150;
	localparam logic [13:0] VOLT_MAX    = 14'd8191;

	// Reciprocals: x/20 (16 bit x), x/5 (20 bit x), x/85 (20 bit x), x/669 (23 bit x)
	localparam logic [15:0] RECIP_20  = 16'd52429;
	localparam logic [19:0] RECIP_5   = 20'd838861;
	localparam logic [21:0] RECIP_85  = 22'd3158065;
	localparam logic [23:0] RECIP_669 = 24'd12839963;

	// Word passed from the accumulator to the scaler at each block close
	typedef struct packed {
		logic [23:0] total;
		logic        updated;
	} close_word_t;

	// Quotient of a 16-bit value by 20
	function automatic logic [11:0] div20(input logic [15:0] x);
		logic [31:0] prod;
		prod = 32'(x) * 32'(RECIP_20);
		return prod[31:20];
	endfunction

	// Remainder of a 16-bit value by 20, given its quotient
	function automatic logic [4:0] rem20(input logic [15:0] x, input logic [11:0] q);
		logic [15:0] diff;
		diff = x - 16'(q * 16'd20);
		return diff[4:0];
	endfunction

endpackage

/* rtl/core/tsavs_scaler.sv */
// ----------------------------------------------------------------------------
// tsavs_scaler: held average and voltage scaling pipeline
// Turns the held total of each block close into the held average and the
// scaled voltage, over four stages and a result register.
// ----------------------------------------------------------------------------
module tsavs_scaler
	import tsavs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        close_valid,
	output logic        close_stall,
	input  close_word_t close_word,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [12:0] voltage,
	output logic [17:0] average,
	output logic        low_range,
	output logic        average_updated
);

	logic        v_s1, v_s2, v_s3, v_s4;
	logic        rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_out;

	logic [23:0] total_s1;
	logic        upd_s1;
	logic [17:0] avg_s2;
	logic        upd_s2;
	logic [25:0] phi_s3;
	logic [24:0] plo_s3;
	logic [17:0] avg_s3;
	logic        upd_s3;
	logic [13:0] vhi_s4;
	logic [13:0] vlo_s4;
	logic [17:0] avg_s4;
	logic        upd_s4;

	logic [39:0] avg_prod;
	logic [41:0] vhi_prod;
	logic [46:0] vlo_prod;
	logic [13:0] volt_sel;
	logic        low_sel;

	// A stage takes a new word when it is empty or its word moves on
	assign rdy_out = !result_valid || !result_stall;
	assign rdy_s4  = !v_s4 || rdy_out;
	assign rdy_s3  = !v_s3 || rdy_s4;
	assign rdy_s2  = !v_s2 || rdy_s3;
	assign rdy_s1  = !v_s1 || rdy_s2;
	assign close_stall = !rdy_s1;

	// Total divided by 80: shift by 16, then divide by 5
	assign avg_prod = 40'(total_s1[23:4]) * 40'(RECIP_5);
	// Divide by 5440 as a shift by 64 and a divide by 85
	assign vhi_prod = 42'(phi_s3[25:6]) * 42'(RECIP_85);
	// Divide by 2676 as a shift by 4 and a divide by 669
	assign vlo_prod = 47'(plo_s3[24:2]) * 47'(RECIP_669);

	always_comb begin
		if (vhi_s4 < LO_LIMIT) begin
			volt_sel = vlo_s4;
			low_sel  = 1'b1;
		end else begin
			volt_sel = vhi_s4;
			low_sel  = 1'b0;
		end
		if (volt_sel > VOLT_MAX) begin
			volt_sel = VOLT_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			v_s4         <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (rdy_s1)  v_s1 <= close_valid;
			if (rdy_s2)  v_s2 <= v_s1;
			if (rdy_s3)  v_s3 <= v_s2;
			if (rdy_s4)  v_s4 <= v_s3;
			if (rdy_out) result_valid <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && close_valid) begin
			total_s1 <= close_word.total;
			upd_s1   <= close_word.updated;
		end
		if (rdy_s2 && v_s1) begin
			avg_s2 <= avg_prod[39:22];
			upd_s2 <= upd_s1;
		end
		if (rdy_s3 && v_s2) begin
			phi_s3 <= 26'(avg_s2) * 26'(HI_GAIN);
			plo_s3 <= 25'(avg_s2) * 25'(LO_GAIN);
			avg_s3 <= avg_s2;
			upd_s3 <= upd_s2;
		end
		if (rdy_s4 && v_s3) begin
			vhi_s4 <= vhi_prod[41:28];
			vlo_s4 <= vlo_prod[46:33];
			avg_s4 <= avg_s3;
			upd_s4 <= upd_s3;
		end
		if (rdy_out && v_s4) begin
			voltage         <= volt_sel[12:0];
			average         <= avg_s4;
			low_range       <= low_sel;
			average_updated <= upd_s4;
		end
	end

endmodule

/* rtl/core/two_stage_averager_voltage_scaler.sv */
// ----------------------------------------------------------------------------
// two_stage_averager_voltage_scaler: block averager with voltage scaling
// Sums qualifying samples into blocks, totals block averages into a held
// average and reports the held average and a scaled voltage at each close.
// ----------------------------------------------------------------------------
//
//  channel   signals                              direction  word
//  sample    sample_valid, sample_stall, sample   in         one sample
//  result    result_valid, result_stall, voltage, out        one per block close
//            average, low_range, average_updated
//  config    cfg_we, cfg_index, cfg_data          in         register write
//
// One sample is taken every cycle unless sample_stall is raised. A sample
// enters an input register, and the accumulator state is updated as it
// leaves; a closing sample then runs through the four-stage scaler and the
// result register before its result is shown. Reset returns the registers to their
// default values and clears all accumulation. A stall on the result side
// fills the scaler stages first; samples that close no block keep flowing
// until a closing sample finds the scaler full.
//
module two_stage_averager_voltage_scaler
	import tsavs_pkg::*;
#(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_index,
	input  logic [CfgDataW-1:0]    cfg_data,
	input  logic                   sample_valid,
	output logic                   sample_stall,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic                   result_valid,
	input  logic                   result_stall,
	output logic [12:0]            voltage,
	output logic [17:0]            average,
	output logic                   low_range,
	output logic                   average_updated
);

	logic [11:0] threshold_q;
	logic [7:0]  block_len_q;
	logic [7:0]  avg_len_q;

	logic [7:0]  count_q;
	logic [20:0] sum_q;
	logic [16:0] sum_quot_q;
	logic [4:0]  sum_rem_q;
	logic [7:0]  blocks_q;
	logic [23:0] total_q;
	logic [23:0] held_total_q;

	logic                   v_s1;
	logic [SAMPLE_BITS-1:0] smp_s1;
	logic                   qual_s1;
	logic [11:0]            q20_s1;
	logic [4:0]             r20_s1;

	logic [SmpMaxW-1:0] smp_ext;
	logic [11:0]        smp_q20;
	logic               closing;
	logic               advance;
	logic               accept;
	logic               sc_stall;
	logic               sc_valid;
	close_word_t        sc_word;

	logic [21:0] sum_raw;
	logic [5:0]  rem_raw;
	logic [24:0] total_raw;
	logic [23:0] total_new;
	logic [7:0]  blocks_inc;
	logic        refresh;

	// Quotient and remainder by 20 are prepared before the sample is summed
	assign smp_ext = SmpMaxW'(sample);
	assign smp_q20 = div20(smp_ext);

	assign closing  = count_q >= block_len_q;
	assign advance  = v_s1 && (!closing || !sc_stall);
	assign sample_stall = v_s1 && !advance;
	assign accept   = sample_valid && !sample_stall;

	assign sum_raw    = {1'b0, sum_q} + 22'(smp_s1);
	assign rem_raw    = 6'(sum_rem_q) + 6'(r20_s1);
	assign total_raw  = {1'b0, total_q} + 25'(sum_quot_q);
	assign total_new  = (total_raw > 25'(TOTAL_MAX)) ? TOTAL_MAX : total_raw[23:0];
	assign blocks_inc = blocks_q + 8'd1;
	assign refresh    = blocks_inc >= avg_len_q;

	assign sc_valid        = v_s1 && closing;
	assign sc_word.total   = refresh ? total_new : held_total_q;
	assign sc_word.updated = refresh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			block_len_q <= BLOCK_LEN_RST;
			avg_len_q   <= AVG_LEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THRESHOLD: threshold_q <= cfg_data[11:0];
				REG_BLOCK_LEN: block_len_q <= cfg_data[7:0];
				REG_AVG_LEN:   avg_len_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!sample_stall) begin
			v_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			smp_s1  <= sample;
			qual_s1 <= smp_ext > SmpMaxW'(threshold_q);
			q20_s1  <= smp_q20;
			r20_s1  <= rem20(smp_ext, smp_q20);
		end
	end

	// Accumulation state moves with the word leaving the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			sum_q        <= '0;
			sum_quot_q   <= '0;
			sum_rem_q    <= '0;
			blocks_q     <= '0;
			total_q      <= '0;
			held_total_q <= '0;
		end else if (advance) begin
			if (closing) begin
				count_q    <= '0;
				sum_q      <= '0;
				sum_quot_q <= '0;
				sum_rem_q  <= '0;
				if (refresh) begin
					blocks_q     <= '0;
					total_q      <= '0;
					held_total_q <= total_new;
				end else begin
					blocks_q <= blocks_inc;
					total_q  <= total_new;
				end
			end else if (qual_s1) begin
				count_q <= count_q + 8'd1;
				if (sum_raw > 22'(SUM_MAX)) begin
					sum_q      <= SUM_MAX;
					sum_quot_q <= SUM_Q_MAX;
					sum_rem_q  <= SUM_R_MAX;
				end else begin
					sum_q <= sum_raw[20:0];
					if (rem_raw >= 6'd20) begin
						sum_rem_q  <= 5'(rem_raw - 6'd20);
						sum_quot_q <= sum_quot_q + 17'(q20_s1) + 17'd1;
					end else begin
						sum_rem_q  <= rem_raw[4:0];
						sum_quot_q <= sum_quot_q + 17'(q20_s1);
					end
				end
			end
		end
	end

	tsavs_scaler u_scaler (
		.clk             (clk),
		.arst_n          (arst_n),
		.close_valid     (sc_valid),
		.close_stall     (sc_stall),
		.close_word      (sc_word),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.voltage         (voltage),
		.average         (average),
		.low_range       (low_range),
		.average_updated (average_updated)
	);

endmodule
